@@ sv/u2l9_pkg.sv @@
// Package for the UTF-8 to Latin-9 converter.
// Holds character constants and the three-byte special codepoint map.
// No dependencies.
package u2l9_pkg;

    localparam logic [7:0] QMARK = 8'h3F;

    localparam logic [15:0] CP_EURO      = 16'h20AC;
    localparam logic [15:0] CP_S_CARON   = 16'h0160;
    localparam logic [15:0] CP_S_CARON_L = 16'h0161;
    localparam logic [15:0] CP_Z_CARON   = 16'h017D;
    localparam logic [15:0] CP_Z_CARON_L = 16'h017E;
    localparam logic [15:0] CP_OE        = 16'h0152;
    localparam logic [15:0] CP_OE_L      = 16'h0153;
    localparam logic [15:0] CP_Y_DIAER   = 16'h0178;
    localparam logic [15:0] CP_CHECK     = 16'h2705;
    localparam logic [15:0] CP_WARNING   = 16'h26A0;
    localparam logic [15:0] CP_VARSEL    = 16'hFE0F;

    // Maps a decoded three-byte codepoint to its Latin-9 character.
    function automatic logic [7:0] map_three(input logic [15:0] cp);
        logic [7:0] ch;
        case (cp)
            CP_EURO:      ch = 8'hA4;
            CP_S_CARON:   ch = 8'hA6;
            CP_S_CARON_L: ch = 8'hA8;
            CP_Z_CARON:   ch = 8'hB4;
            CP_Z_CARON_L: ch = 8'hB8;
            CP_OE:        ch = 8'hBC;
            CP_OE_L:      ch = 8'hBD;
            CP_Y_DIAER:   ch = 8'hBE;
            CP_CHECK:     ch = 8'hBB;
            CP_WARNING:   ch = 8'hA4;
            CP_VARSEL:    ch = 8'h20;
            default:      ch = (cp[15:8] == 8'h00) ? cp[7:0] : QMARK;
        endcase
        return ch;
    endfunction

endpackage

@@ sv/utf8_to_latin9_converter_core.sv @@
// Top level of the UTF-8 to Latin-9 converter.
// Uses u2l9_pkg for constants and the special codepoint map.
//
//   Channel  Handshake                   Beat payload
//   input    in_valid / in_stall         in_byte, end_of_text
//   output   out_valid / out_stall       out_char, run_last
//
// Each accepted byte is decoded in the cycle it is accepted; its zero to three
// characters go into a three-entry result register that drains one per cycle while
// out_stall is low. A byte is taken when none is pending or the last one leaves, so
// plain text runs at one byte per cycle without stalls; a byte with more than one
// result stalls the input until it drains. Reset empties the held sequence and results.
module utf8_to_latin9_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last
);
    import u2l9_pkg::*;

    logic [1:0] held_cnt_reg;
    logic [1:0] held_cnt_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;
    logic [7:0] first_cont_reg;
    logic [7:0] first_cont_next;

    logic [7:0] pend_char_reg [3];
    logic [1:0] pend_cnt_reg;

    logic [7:0] res_char [3];
    logic [1:0] res_cnt;
    logic       do_fresh;
    logic       is_cont;
    logic       is_lead;
    logic       accept;
    logic       take;

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign is_lead = (in_byte[7:5] == 3'b110) || (in_byte[7:4] == 4'b1110);

    assign out_valid = (pend_cnt_reg != 2'd0);
    assign out_char  = pend_char_reg[0];
    assign run_last  = (pend_cnt_reg == 2'd1);
    assign in_stall  = !((pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && !out_stall));
    assign accept    = in_valid && !in_stall;
    assign take      = out_valid && !out_stall;

    always_comb
    begin
        res_char[0]     = QMARK;
        res_char[1]     = QMARK;
        res_char[2]     = QMARK;
        res_cnt         = 2'd0;
        do_fresh        = 1'b0;
        held_cnt_next   = held_cnt_reg;
        lead_byte_next  = lead_byte_reg;
        first_cont_next = first_cont_reg;

        case (held_cnt_reg)
            2'd0:
            begin
                do_fresh = 1'b1;
            end
            2'd1:
            begin
                if (!is_cont)
                begin
                    res_cnt       = 2'd1;
                    held_cnt_next = 2'd0;
                    do_fresh      = 1'b1;
                end
                else if (lead_byte_reg[7:5] == 3'b110)
                begin
                    if (lead_byte_reg[4:2] == 3'b000)
                    begin
                        res_char[0] = {lead_byte_reg[1:0], in_byte[5:0]};
                    end
                    res_cnt       = 2'd1;
                    held_cnt_next = 2'd0;
                end
                else
                begin
                    first_cont_next = in_byte;
                    held_cnt_next   = 2'd2;
                end
            end
            default:
            begin
                if (is_cont)
                begin
                    res_char[0] = map_three({lead_byte_reg[3:0], first_cont_reg[5:0],
                                             in_byte[5:0]});
                    res_cnt       = 2'd1;
                    held_cnt_next = 2'd0;
                end
                else
                begin
                    res_cnt       = 2'd2;
                    held_cnt_next = 2'd0;
                    do_fresh      = 1'b1;
                end
            end
        endcase

        if (do_fresh)
        begin
            if (!in_byte[7])
            begin
                res_char[res_cnt] = in_byte;
                res_cnt           = res_cnt + 2'd1;
            end
            else if (is_lead)
            begin
                lead_byte_next = in_byte;
                held_cnt_next  = 2'd1;
            end
            else
            begin
                res_cnt = res_cnt + 2'd1;
            end
        end

        if (end_of_text)
        begin
            res_cnt       = res_cnt + held_cnt_next;
            held_cnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg   <= 2'd0;
            lead_byte_reg  <= 8'h00;
            first_cont_reg <= 8'h00;
            pend_cnt_reg   <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                held_cnt_reg   <= held_cnt_next;
                lead_byte_reg  <= lead_byte_next;
                first_cont_reg <= first_cont_next;
                pend_cnt_reg   <= res_cnt;
            end
            else if (take)
            begin
                pend_cnt_reg <= pend_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_char_reg[0] <= res_char[0];
            pend_char_reg[1] <= res_char[1];
            pend_char_reg[2] <= res_char[2];
        end
        else if (take)
        begin
            pend_char_reg[0] <= pend_char_reg[1];
            pend_char_reg[1] <= pend_char_reg[2];
        end
    end

`ifndef SYNTHESIS
    a_held_never_three: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg != 2'd3)
        else $error("held byte count reached three");

    a_eot_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> held_cnt_reg == 2'd0)
        else $error("bytes still held after end of text");

    a_ascii_passes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (held_cnt_reg == 2'd0) && !in_byte[7]
        |=> out_valid && run_last && (out_char == $past(in_byte)))
        else $error("ASCII byte did not pass straight through");
`endif

endmodule
